// ===== src/cdq_pkg.sv =====
// Shared types and constants for the circular double-ended queue.
package cdq_pkg;

    // Default number of entries in the store
    localparam int DEPTH_DEFAULT = 16;
    // Width of one stored value
    localparam int DATA_W = 32;

    // Command codes carried by an input transfer
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted input transfer
        logic exec;      // apply the captured command to the queue state
        logic read_out;  // move the popped word into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pop_ok;    // captured command is a pop that will succeed
        logic out_free;  // output register can take a new result this cycle
    } t_dp_sts;

endpackage

// ===== src/circular_deque.sv =====
// Top level of the circular double-ended queue.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+---------------------------------------------
//  input   | i_valid  | o_stall  | i_cmd, i_push_value
//  output  | o_valid  | i_stall  | o_pop_value, o_status, o_is_full, o_is_empty
//
// A push or a rejected command is executed in S_EXEC, which loads its result into
// the output register; a successful pop adds a registered read of the store (S_READ).
// A new command is taken while the previous result still waits in the output
// register; it completes up to the point where it needs that register.
// Reset (synchronous, active low) empties the queue; the store is not cleared.
// A stalled output holds its result, and the command behind it waits.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  cdq_pkg::t_cmd                     i_cmd,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_push_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [cdq_pkg::DATA_W-1:0] o_pop_value,
    output cdq_pkg::t_status                  o_status,
    output logic                              o_is_full,
    output logic                              o_is_empty
);

    cdq_pkg::t_dp_cmd ctl;
    cdq_pkg::t_dp_sts sts;

    // Command sequencing
    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // Queue state, store and result register
    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .i_stall      (i_stall),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .o_valid      (o_valid),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty)
    );

endmodule

// ===== src/cdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cdq_dpath.sv =====
// Datapath: input capture, head/tail/occupancy registers, store and output register.
module cdq_dpath #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cdq_pkg::t_cmd                     i_cmd,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_push_value,
    input  logic                              i_stall,
    input  cdq_pkg::t_dp_cmd                  i_ctl,
    output cdq_pkg::t_dp_sts                  o_sts,
    output logic                              o_valid,
    output logic signed [cdq_pkg::DATA_W-1:0] o_pop_value,
    output cdq_pkg::t_status                  o_status,
    output logic                              o_is_full,
    output logic                              o_is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

    // Captured command
    cdq_pkg::t_cmd               r_cmd;
    logic [cdq_pkg::DATA_W-1:0]  r_value;

    // Queue state
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [OW-1:0] r_occ,  n_occ;

    // Output register
    logic                               r_out_valid;
    logic signed [cdq_pkg::DATA_W-1:0]  r_pop_value, n_pop_value;
    cdq_pkg::t_status                   r_status, n_status;
    logic                               r_full, n_full;
    logic                               r_empty, n_empty;
    logic                               out_load;

    // Store access
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [cdq_pkg::DATA_W-1:0]  ram_rdata;

    logic is_push;
    logic is_front;
    logic q_full;
    logic q_empty;
    logic push_ok;
    logic pop_ok;
    logic out_free;

    // Command decode against current state
    assign is_push  = (r_cmd == cdq_pkg::CMD_PUSH_FRONT) || (r_cmd == cdq_pkg::CMD_PUSH_BACK);
    assign is_front = (r_cmd == cdq_pkg::CMD_PUSH_FRONT) || (r_cmd == cdq_pkg::CMD_POP_FRONT);
    assign q_full   = (r_occ == FULL_OCC);
    assign q_empty  = (r_occ == '0);
    assign push_ok  = is_push && !q_full;
    assign pop_ok   = !is_push && !q_empty;
    assign out_free = !r_out_valid || !i_stall;

    assign o_sts.pop_ok   = pop_ok;
    assign o_sts.out_free = out_free;

    // Capture the accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= cdq_pkg::CMD_PUSH_FRONT;
        end else if (i_ctl.load_in) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_value <= i_push_value;
        end
    end

    // Next pointers, occupancy and store access
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_occ     = r_occ;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_re    = 1'b0;
        ram_raddr = is_front ? r_head : r_tail;
        if (i_ctl.exec) begin
            if (push_ok) begin
                ram_we = 1'b1;
                n_occ  = r_occ + OW'(1);
                if (q_empty) begin
                    n_head    = '0;
                    n_tail    = '0;
                    ram_waddr = '0;
                end else if (is_front) begin
                    n_head    = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
                    ram_waddr = n_head;
                end else begin
                    n_tail    = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
                    ram_waddr = n_tail;
                end
            end else if (pop_ok) begin
                ram_re = 1'b1;
                n_occ  = r_occ - OW'(1);
                if (is_front) begin
                    n_head = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                end else begin
                    n_tail = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);
                end
                // last entry gone: both indices return to slot 0
                if (n_occ == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    // Entry store
    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result selection: pushes and rejects finish at exec, pops after the read
    always_comb begin
        out_load    = 1'b0;
        n_pop_value = '0;
        n_status    = cdq_pkg::ST_DONE;
        n_full      = (n_occ == FULL_OCC);
        n_empty     = (n_occ == '0);
        if (i_ctl.read_out) begin
            out_load    = 1'b1;
            n_pop_value = $signed(ram_rdata);
            n_full      = q_full;
            n_empty     = q_empty;
        end else if (i_ctl.exec && !pop_ok) begin
            out_load = 1'b1;
            if (is_push) begin
                n_status = q_full ? cdq_pkg::ST_FULL : cdq_pkg::ST_DONE;
            end else begin
                n_status = cdq_pkg::ST_EMPTY;
            end
        end
    end

    // Output register and its valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_pop_value <= n_pop_value;
            r_status    <= n_status;
            r_full      <= n_full;
            r_empty     <= n_empty;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;
    assign o_is_full   = r_full;
    assign o_is_empty  = r_empty;

endmodule

// ===== src/cdq_ctrl.sv =====
// Controller: sequences capture, execute and read-back for one command.
module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  cdq_pkg::t_dp_sts i_sts,
    output cdq_pkg::t_dp_cmd o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_ctl.load_in  = 1'b0;
        o_ctl.exec     = 1'b0;
        o_ctl.read_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // a pop starts its read at once; others wait for the output slot
                if (i_sts.pop_ok) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_READ;
                end else if (i_sts.out_free) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_ctl.read_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
